// ===== sv/llvp_pkg.sv =====
// Shared types, constants and the fixed-point sine builder for the lane line
// vanishing point block. No dependencies; the controller, datapath and top level import it.
`default_nettype none
package llvp_pkg;

    // Field widths.
    localparam int RHO_W  = 12;
    localparam int ANG_W  = 8;
    localparam int CFG_W  = 12;
    localparam int Y_W    = 20;
    localparam int V_W    = 24;
    localparam int IDX_W  = 1;

    // Default number of fraction bits in the sine and cosine values.
    localparam int TRIG_FRAC_BITS_DEF = 16;

    // Angle rules, in whole degrees.
    localparam int ANG_DROP_LO = 69;
    localparam int ANG_DROP_HI = 103;
    localparam int ANG_RIGHT   = 90;
    localparam int ANG_LIMIT   = 180;
    localparam int QUAD_DEG    = 90;

    // Saturation limits.
    localparam int Y_MAX_I = 524287;
    localparam int Y_MIN_I = -524288;
    localparam int V_MAX_I = 8388607;
    localparam int V_MIN_I = -8388608;

    // Configuration register reset value and indexes.
    localparam logic [CFG_W-1:0] CFG_RESET = 12'd320;
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_VANISH_SCALE = 1'd1;

    // pi in Q30.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_Y_SET,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_V_SET,
        ST_V_GO,
        ST_V_WAIT,
        ST_M_MUL,
        ST_M_GO,
        ST_M_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_Y_SETUP,
        OP_Y_STORE,
        OP_V_SETUP,
        OP_V_STORE,
        OP_M_SETUP,
        OP_M_STORE,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic       div_start;
        logic       take;
    } cmd_t;

    typedef struct packed {
        logic both;
        logic den_zero;
        logic div_done;
        logic out_free;
    } status_t;

    // Sine of k degrees (k up to 90) by a Taylor series in Q30, rounded half
    // up to frac fraction bits. Used only to build a constant table.
    function automatic longint unsigned sin_fix(input int k, input int frac);
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        pos  = pos + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
        neg  = neg + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd272;
        pos  = pos + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd342;
        neg  = neg + term;
        s = (pos > neg) ? (pos - neg) : 64'd0;
        return (s + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage
`default_nettype wire

// ===== sv/llvp_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating
// toward zero. Depends on nothing but its parameters.
`default_nettype none
module llvp_div #(
    parameter int DIV_W = 55,
    parameter int DVS_W = 23
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DIV_W-1:0] dividend,
    input  wire logic signed [DVS_W-1:0] divisor,
    output logic signed [DIV_W-1:0]      quotient,
    output logic                         done
);

    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] d_reg;
    logic             neg_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] trial;
    logic             q_bit;
    logic             last_step;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[DIV_W-1]};
        trial     = {1'b0, rem_sh} - {2'b00, d_reg};
        q_bit     = ~trial[DVS_W+1];
        last_step = (cnt_reg == CNT_W'(DIV_W - 1));
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Magnitudes on load, then the quotient shifts in from the right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            d_reg   <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[DIV_W-1] ^ divisor[DVS_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign done     = done_reg;

endmodule
`default_nettype wire

// ===== sv/llvp_datapath.sv =====
// Datapath: candidate lines, configuration, sine table, divider operands,
// line y values, vanishing point and the output register.
// Depends on llvp_pkg and llvp_div.
`default_nettype none
module llvp_datapath #(
    parameter int TRIG_FRAC_BITS = llvp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire llvp_pkg::cmd_t                       cmd,
    output llvp_pkg::status_t                         status,
    input  wire logic                                 line_valid,
    input  wire logic signed [llvp_pkg::RHO_W-1:0]    rho,
    input  wire logic [llvp_pkg::ANG_W-1:0]           theta_deg,
    input  wire logic                                 cfg_valid,
    input  wire logic [llvp_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [llvp_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output logic                                      found,
    output logic                                      div_zero,
    output logic                                      saturated,
    output logic signed [llvp_pkg::Y_W-1:0]           left_y_start,
    output logic signed [llvp_pkg::Y_W-1:0]           left_y_end,
    output logic signed [llvp_pkg::Y_W-1:0]           right_y_start,
    output logic signed [llvp_pkg::Y_W-1:0]           right_y_end,
    output logic signed [llvp_pkg::V_W-1:0]           vanish_x,
    output logic signed [llvp_pkg::V_W-1:0]           vanish_y
);
    import llvp_pkg::*;

    localparam int F       = TRIG_FRAC_BITS;
    localparam int SIN_W   = F + 1;
    localparam int COS_W   = F + 2;
    localparam int NUM_W   = F + 16;
    localparam int DIFF_W  = Y_W + 1;
    localparam int DEN_W   = Y_W + 2;
    localparam int VX_W    = CFG_W + 1 + DIFF_W;
    localparam int PROD_W  = DIFF_W + VX_W;
    localparam int DIV_W   = (NUM_W > PROD_W) ? NUM_W : PROD_W;
    localparam int DVS_W   = (COS_W > DEN_W + 1) ? COS_W : DEN_W + 1;
    localparam int QIDX_W  = 7;

    typedef logic [SIN_W-1:0] sin_rom_t [0:QUAD_DEG];

    function automatic sin_rom_t build_rom();
        sin_rom_t rom;
        for (int k = 0; k <= QUAD_DEG; k++)
        begin
            rom[k] = SIN_W'(sin_fix(k, F));
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_rom();

    localparam logic signed [DIV_W-1:0]  QY_MAX = DIV_W'(Y_MAX_I);
    localparam logic signed [DIV_W-1:0]  QY_MIN = DIV_W'(Y_MIN_I);
    localparam logic signed [VX_W-1:0]   VX_MAX = VX_W'(V_MAX_I);
    localparam logic signed [VX_W-1:0]   VX_MIN = VX_W'(V_MIN_I);
    localparam logic signed [DIV_W:0]    VY_MAX = (DIV_W + 1)'(V_MAX_I);
    localparam logic signed [DIV_W:0]    VY_MIN = (DIV_W + 1)'(V_MIN_I);

    // Registers.
    logic signed [RHO_W-1:0] l_rho_reg;
    logic [ANG_W-1:0]        l_ang_reg;
    logic signed [RHO_W-1:0] r_rho_reg;
    logic [ANG_W-1:0]        r_ang_reg;
    logic [CFG_W-1:0]        width_reg;
    logic [CFG_W-1:0]        scale_reg;
    logic signed [DIV_W-1:0] div_a_reg;
    logic signed [DVS_W-1:0] div_b_reg;
    logic signed [Y_W-1:0]   p_reg [0:3];
    logic signed [VX_W-1:0]  vx_reg;
    logic signed [V_W-1:0]   vy_reg;
    logic                    sat_reg;
    logic                    out_valid_reg;
    logic                    found_reg;
    logic                    div_zero_reg;
    logic                    sat_out_reg;
    logic signed [Y_W-1:0]   ly0_reg;
    logic signed [Y_W-1:0]   ly1_reg;
    logic signed [Y_W-1:0]   ry0_reg;
    logic signed [Y_W-1:0]   ry1_reg;
    logic signed [V_W-1:0]   vx_out_reg;
    logic signed [V_W-1:0]   vy_out_reg;

    // Combinational signals.
    logic                    line_ok;
    logic signed [RHO_W-1:0] sel_rho;
    logic [ANG_W-1:0]        sel_ang;
    logic [CFG_W-1:0]        sel_x;
    logic                    low_quad;
    logic [QIDX_W-1:0]       sin_idx;
    logic [QIDX_W-1:0]       cos_idx;
    logic [SIN_W-1:0]        sin_val;
    logic [SIN_W-1:0]        cos_mag;
    logic signed [COS_W-1:0] cos_val;
    logic signed [F+14:0]    x_cos;
    logic signed [NUM_W-1:0] num;
    logic [CFG_W-1:0]        s_eff;
    logic signed [DIFF_W-1:0] d31;
    logic signed [DIFF_W-1:0] d21;
    logic signed [DEN_W-1:0] den;
    logic signed [DIV_W-1:0] quot;
    logic                    div_done;
    logic                    y_hi;
    logic                    y_lo;
    logic signed [Y_W-1:0]   y_clamped;
    logic                    vx_hi;
    logic                    vx_lo;
    logic signed [V_W-1:0]   vx_clamped;
    logic signed [DIV_W:0]   vy_sum;
    logic                    vy_hi;
    logic                    vy_lo;
    logic signed [V_W-1:0]   vy_clamped;

    // Line acceptance test for an incoming item.
    assign line_ok = line_valid && (theta_deg < ANG_W'(ANG_LIMIT))
                     && !((theta_deg >= ANG_W'(ANG_DROP_LO))
                          && (theta_deg <= ANG_W'(ANG_DROP_HI)));

    // Operand selection and trig lookup for one line y value.
    always_comb
    begin
        sel_rho  = cmd.sel[1] ? r_rho_reg : l_rho_reg;
        sel_ang  = cmd.sel[1] ? r_ang_reg : l_ang_reg;
        sel_x    = cmd.sel[0] ? width_reg : '0;
        low_quad = (sel_ang <= ANG_W'(QUAD_DEG));
        sin_idx  = low_quad ? sel_ang[QIDX_W-1:0]
                            : QIDX_W'(ANG_W'(ANG_LIMIT) - sel_ang);
        cos_idx  = low_quad ? QIDX_W'(ANG_W'(QUAD_DEG) - sel_ang)
                            : QIDX_W'(sel_ang - ANG_W'(QUAD_DEG));
        sin_val  = SIN_ROM[sin_idx];
        cos_mag  = SIN_ROM[cos_idx];
        cos_val  = low_quad ? $signed({1'b0, cos_mag}) : -$signed({1'b0, cos_mag});
        x_cos    = (F + 15)'($signed({1'b0, sel_x})) * (F + 15)'(cos_val);
        num      = (NUM_W'(sel_rho) <<< F) - NUM_W'(x_cos);
    end

    // Intersection terms from the stored y values.
    always_comb
    begin
        s_eff = (scale_reg == '0) ? CFG_W'(1) : scale_reg;
        d31   = DIFF_W'(p_reg[2]) - DIFF_W'(p_reg[0]);
        d21   = DIFF_W'(p_reg[1]) - DIFF_W'(p_reg[0]);
        den   = DEN_W'(p_reg[1]) - DEN_W'(p_reg[0]) + DEN_W'(p_reg[2])
                - DEN_W'(p_reg[3]);
    end

    // Clamping of the divider result and the vanishing point.
    always_comb
    begin
        y_hi       = (quot > QY_MAX);
        y_lo       = (quot < QY_MIN);
        y_clamped  = y_hi ? Y_W'(Y_MAX_I) : (y_lo ? Y_W'(Y_MIN_I) : Y_W'(quot));
        vx_hi      = (vx_reg > VX_MAX);
        vx_lo      = (vx_reg < VX_MIN);
        vx_clamped = vx_hi ? V_W'(V_MAX_I) : (vx_lo ? V_W'(V_MIN_I) : V_W'(vx_reg));
        vy_sum     = (DIV_W + 1)'(quot) + (DIV_W + 1)'(p_reg[0]);
        vy_hi      = (vy_sum > VY_MAX);
        vy_lo      = (vy_sum < VY_MIN);
        vy_clamped = vy_hi ? V_W'(V_MAX_I) : (vy_lo ? V_W'(V_MIN_I) : V_W'(vy_sum));
    end

    llvp_div #(
        .DIV_W(DIV_W),
        .DVS_W(DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .quotient (quot),
        .done     (div_done)
    );

    // Candidates, configuration, saturation flag and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_rho_reg     <= '0;
            l_ang_reg     <= '0;
            r_rho_reg     <= '0;
            r_ang_reg     <= '0;
            width_reg     <= CFG_RESET;
            scale_reg     <= CFG_RESET;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    scale_reg <= cfg_data;
                end
            end
            // A new result may replace the one taken in the same cycle.
            if (cmd.op == OP_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_Y_STORE:
                begin
                    if (y_hi || y_lo)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_V_STORE:
                begin
                    if (VX_W'(quot) > VX_MAX || VX_W'(quot) < VX_MIN)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_M_STORE:
                begin
                    if (vy_hi || vy_lo)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_OUT_LOAD:
                begin
                    sat_reg       <= 1'b0;
                    l_rho_reg     <= '0;
                    l_ang_reg     <= '0;
                    r_rho_reg     <= '0;
                    r_ang_reg     <= '0;
                end
                default:
                begin
                end
            endcase
            if (cmd.take && line_ok)
            begin
                if (theta_deg < ANG_W'(ANG_RIGHT))
                begin
                    if (l_ang_reg < theta_deg)
                    begin
                        l_rho_reg <= rho;
                        l_ang_reg <= theta_deg;
                    end
                end
                else if (r_ang_reg < theta_deg)
                begin
                    r_rho_reg <= rho;
                    r_ang_reg <= theta_deg;
                end
            end
        end
    end

    // Divider operands, intermediate values and the result register.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_Y_SETUP:
            begin
                div_a_reg <= DIV_W'(num);
                div_b_reg <= DVS_W'($signed({1'b0, sin_val}));
            end
            OP_Y_STORE:
            begin
                p_reg[cmd.sel] <= y_clamped;
            end
            OP_V_SETUP:
            begin
                div_a_reg <= DIV_W'(VX_W'($signed({1'b0, s_eff})) * VX_W'(d31));
                div_b_reg <= DVS_W'(den);
            end
            OP_V_STORE:
            begin
                vx_reg <= VX_W'(quot);
            end
            OP_M_SETUP:
            begin
                div_a_reg <= DIV_W'(d21) * DIV_W'(vx_reg);
                div_b_reg <= DVS_W'($signed({1'b0, s_eff}));
            end
            OP_M_STORE:
            begin
                vy_reg <= vy_clamped;
            end
            OP_OUT_LOAD:
            begin
                found_reg    <= status.both;
                div_zero_reg <= status.both && status.den_zero;
                sat_out_reg  <= status.both && sat_reg;
                ly0_reg      <= status.both ? p_reg[0] : '0;
                ly1_reg      <= status.both ? p_reg[1] : '0;
                ry0_reg      <= status.both ? p_reg[2] : '0;
                ry1_reg      <= status.both ? p_reg[3] : '0;
                vx_out_reg   <= (status.both && !status.den_zero) ? vx_clamped : '0;
                vy_out_reg   <= (status.both && !status.den_zero) ? vy_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller.
    always_comb
    begin
        status.both     = (l_ang_reg != '0) && (r_ang_reg != '0);
        status.den_zero = (den == '0);
        status.div_done = div_done;
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign div_zero      = div_zero_reg;
    assign saturated     = sat_out_reg;
    assign left_y_start  = ly0_reg;
    assign left_y_end    = ly1_reg;
    assign right_y_start = ry0_reg;
    assign right_y_end   = ry1_reg;
    assign vanish_x      = vx_out_reg;
    assign vanish_y      = vy_out_reg;

endmodule
`default_nettype wire

// ===== sv/llvp_ctrl.sv =====
// Controller state machine: sequences the four line y divisions and the two
// intersection divisions. Depends on llvp_pkg.
`default_nettype none
module llvp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               frame_last,
    output logic                    in_stall,
    input  wire llvp_pkg::status_t  status,
    output llvp_pkg::cmd_t          cmd
);
    import llvp_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && frame_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                sel_next   = '0;
                state_next = status.both ? ST_Y_SET : ST_FINISH;
            end
            ST_Y_SET:
            begin
                state_next = ST_Y_GO;
            end
            ST_Y_GO:
            begin
                state_next = ST_Y_WAIT;
            end
            ST_Y_WAIT:
            begin
                if (status.div_done)
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = (sel_reg == 2'd3) ? ST_V_SET : ST_Y_SET;
                end
            end
            ST_V_SET:
            begin
                state_next = status.den_zero ? ST_FINISH : ST_V_GO;
            end
            ST_V_GO:
            begin
                state_next = ST_V_WAIT;
            end
            ST_V_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_M_MUL;
                end
            end
            ST_M_MUL:
            begin
                state_next = ST_M_GO;
            end
            ST_M_GO:
            begin
                state_next = ST_M_WAIT;
            end
            ST_M_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.sel       = sel_reg;
        cmd.div_start = 1'b0;
        cmd.take      = 1'b0;
        in_stall      = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
            end
            ST_Y_SET:
            begin
                cmd.op = OP_Y_SETUP;
            end
            ST_Y_GO, ST_V_GO, ST_M_GO:
            begin
                cmd.div_start = 1'b1;
            end
            ST_Y_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_Y_STORE;
                end
            end
            ST_V_SET:
            begin
                cmd.op = OP_V_SETUP;
            end
            ST_V_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_V_STORE;
                end
            end
            ST_M_MUL:
            begin
                cmd.op = OP_M_SETUP;
            end
            ST_M_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_M_STORE;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_OUT_LOAD;
                end
            end
            default:
            begin
            end
        endcase
    end

    // A frame end always leads to the check state.
    a_last_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && frame_last) |=> (state_reg == ST_CHECK))
        else $error("frame end did not start the result sequence");

    // The result is loaded only once, then the block returns to idle.
    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_LOAD) |=> (state_reg == ST_IDLE))
        else $error("result load not followed by idle");

    // Divider completion is seen only while a division is awaited.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_Y_WAIT || state_reg == ST_V_WAIT
                             || state_reg == ST_M_WAIT))
        else $error("divider finished outside a wait state");

    // The fourth line y value leads to the intersection setup.
    a_y_to_v: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Y_WAIT && status.div_done && sel_reg == 2'd3)
        |=> (state_reg == ST_V_SET))
        else $error("line y sequence did not hand over to intersection");

endmodule
`default_nettype wire

// ===== sv/lane_line_vanishing_point.sv =====
// A line item is taken while the controller is idle. A frame end with a side missing
// passes the check and finish states, and out_valid is registered on the result load.
// A frame end with both sides runs six serial divisions on one radix-2 divider (DIV_W is
// 55 at 16 fraction bits), and only four when the denominator is zero.
// One frame at a time; a finished frame waiting on out_stall holds off the input.
// Reset clears both candidates and out_valid, and sets both registers to 320.
// Top level; depends on llvp_pkg, llvp_ctrl, llvp_datapath and llvp_div.
`default_nettype none
module lane_line_vanishing_point #(
    parameter int TRIG_FRAC_BITS = llvp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              line_valid,
    input  wire logic signed [llvp_pkg::RHO_W-1:0] rho,
    input  wire logic [llvp_pkg::ANG_W-1:0]        theta_deg,
    input  wire logic                              frame_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   found,
    output logic                                   div_zero,
    output logic                                   saturated,
    output logic signed [llvp_pkg::Y_W-1:0]        left_y_start,
    output logic signed [llvp_pkg::Y_W-1:0]        left_y_end,
    output logic signed [llvp_pkg::Y_W-1:0]        right_y_start,
    output logic signed [llvp_pkg::Y_W-1:0]        right_y_end,
    output logic signed [llvp_pkg::V_W-1:0]        vanish_x,
    output logic signed [llvp_pkg::V_W-1:0]        vanish_y,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [llvp_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [llvp_pkg::CFG_W-1:0]        cfg_data
);
    import llvp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    llvp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .frame_last (frame_last),
        .in_stall   (in_stall),
        .status     (status),
        .cmd        (cmd)
    );

    llvp_datapath #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .line_valid    (line_valid),
        .rho           (rho),
        .theta_deg     (theta_deg),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .found         (found),
        .div_zero      (div_zero),
        .saturated     (saturated),
        .left_y_start  (left_y_start),
        .left_y_end    (left_y_end),
        .right_y_start (right_y_start),
        .right_y_end   (right_y_end),
        .vanish_x      (vanish_x),
        .vanish_y      (vanish_y)
    );

endmodule
`default_nettype wire
